// ----- design/ssps_pkg.sv -----
// Shared types and codes for the step sequencer pattern store.
// No dependencies; used by the front, the back and the top level.
`timescale 1ns / 1ps
package ssps_pkg;

   // action codes on the request side
   localparam logic [3:0] ACT_TICK      = 4'd0;
   localparam logic [3:0] ACT_RESTART   = 4'd1;
   localparam logic [3:0] ACT_SELECT    = 4'd2;
   localparam logic [3:0] ACT_COPY      = 4'd3;
   localparam logic [3:0] ACT_CLR_ALL   = 4'd4;
   localparam logic [3:0] ACT_CLR_PART  = 4'd5;
   localparam logic [3:0] ACT_ADD       = 4'd6;
   localparam logic [3:0] ACT_REMOVE    = 4'd7;
   localparam logic [3:0] ACT_CLR_STEP  = 4'd8;
   localparam logic [3:0] ACT_QUERY     = 4'd9;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;
   localparam int SHOWN_SLOTS = 4;

   typedef enum logic [3:0] {
      KIND_TICK, KIND_RESTART, KIND_SELECT, KIND_COPY, KIND_CLR_ALL,
      KIND_CLR_PART, KIND_ADD, KIND_REMOVE, KIND_CLR_STEP, KIND_QUERY, KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  tpart;
      logic [7:0]  note;
      logic [3:0]  sidx;   // already reduced modulo the step count
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TICK, ST_COPY_RD, ST_COPY_WR, ST_EDIT_RD, ST_EDIT_WR,
      ST_SHOW_RD, ST_SHOW_WAIT, ST_RESP
   } back_state_type;

endpackage

// ----- design/ssps_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ssps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/ssps_front.sv -----
// Front end: accepts request items, classifies them and holds them in a
// two-entry command queue. Depends on ssps_pkg.
`timescale 1ns / 1ps
module ssps_front #(
   parameter int STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ssps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [3:0]                     req_tuser,
   output ssps_pkg::cmd_chan_type         cmd_out,
   input  logic                           cmd_pop
);
   ssps_pkg::cmd_type q_ff [2];
   ssps_pkg::cmd_type q_in [2];
   logic [1:0]        cnt_ff, cnt_in;
   ssps_pkg::cmd_type dec;
   logic              push;

   // reduce the step index modulo STEPS by conditional subtraction
   function automatic logic [3:0] wrap_step(input logic [3:0] v);
      logic [4:0] r;
      r = {1'b0, v};
      for (int k = 0; k < 8; k++) begin
         if (int'(r) >= STEPS) begin
            r = r - 5'(STEPS);
         end
      end
      return r[3:0];
   endfunction

   always_comb begin
      dec.tpart = req_tdata[3:0];
      dec.note  = req_tdata[11:4];
      dec.sidx  = wrap_step(req_tdata[15:12]);
      case (req_tuser)
         ssps_pkg::ACT_TICK:     dec.kind = ssps_pkg::KIND_TICK;
         ssps_pkg::ACT_RESTART:  dec.kind = ssps_pkg::KIND_RESTART;
         ssps_pkg::ACT_SELECT:   dec.kind = ssps_pkg::KIND_SELECT;
         ssps_pkg::ACT_COPY:     dec.kind = ssps_pkg::KIND_COPY;
         ssps_pkg::ACT_CLR_ALL:  dec.kind = ssps_pkg::KIND_CLR_ALL;
         ssps_pkg::ACT_CLR_PART: dec.kind = ssps_pkg::KIND_CLR_PART;
         ssps_pkg::ACT_ADD:      dec.kind = ssps_pkg::KIND_ADD;
         ssps_pkg::ACT_REMOVE:   dec.kind = ssps_pkg::KIND_REMOVE;
         ssps_pkg::ACT_CLR_STEP: dec.kind = ssps_pkg::KIND_CLR_STEP;
         ssps_pkg::ACT_QUERY:    dec.kind = ssps_pkg::KIND_QUERY;
         default:                dec.kind = ssps_pkg::KIND_NOP;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in = cnt_ff;
      if (cmd_pop && cnt_ff != 2'd0) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = dec;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign cmd_out.valid = (cnt_ff != 2'd0);
   assign cmd_out.cmd   = q_ff[0];
endmodule

// ----- design/ssps_back.sv -----
// Back end: executes queued commands against the pattern RAM and holds the
// playback state and the result register. Depends on ssps_pkg and ssps_ram.
`timescale 1ns / 1ps
module ssps_back #(
   parameter int PARTS          = 8,
   parameter int STEPS          = 16,
   parameter int NOTES_PER_STEP = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ssps_pkg::cmd_chan_type          cmd_in,
   output logic                            cmd_pop,
   input  logic [4:0]                      steps_in_use,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ssps_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   localparam int DEPTH = PARTS * STEPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = NOTES_PER_STEP * 8;
   localparam int PW    = $clog2(STEPS);
   localparam int CW    = $clog2(STEPS + 1);

   ssps_pkg::back_state_type st_ff, st_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [3:0]     act_ff, act_in;
   logic [3:0]     que_ff, que_in;
   logic           qv_ff, qv_in;
   logic           flag_ff, flag_in;
   logic [PW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  val_ff, val_in;
   logic [WW-1:0]  shown_ff, shown_in;
   logic           added_ff, added_in;
   ssps_pkg::cmd_type cmd_ff, cmd_in_r;
   logic           rv_ff, rv_in;
   logic [ssps_pkg::RSP_DATA_W-1:0] rd_ff, rd_in;
   logic [DEPTH-1:0] vld_ff;
   logic           rdv_ff;

   logic           wr_en, rd_en, clr_all, clr_part;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [WW-1:0]  wr_data, rd_data, rword, edited;
   logic [CW-1:0]  n;
   logic           has, done, ed_added, found, empty;
   logic [63:0]    shown_ext;

   ssps_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries never written since their last clear read as zero
   assign rword = rdv_ff ? rd_data : '0;

   function automatic logic [AW-1:0] addr_of(input logic [3:0] p, input logic [5:0] s);
      return AW'(int'(p) * STEPS + int'(s));
   endfunction

   always_comb begin
      if (steps_in_use == 5'd0) begin
         n = CW'(1);
      end else if (int'(steps_in_use) > STEPS) begin
         n = CW'(STEPS);
      end else begin
         n = CW'(steps_in_use);
      end
   end

   // step edit: add into the first free slot, remove matches, or clear
   always_comb begin
      edited = rword;
      has = 1'b0;
      done = 1'b0;
      ed_added = 1'b0;
      for (int j = 0; j < NOTES_PER_STEP; j++) begin
         if (rword[j*8 +: 8] == cmd_ff.note) begin
            has = 1'b1;
         end
      end
      case (cmd_ff.kind)
         ssps_pkg::KIND_ADD: begin
            for (int j = 0; j < NOTES_PER_STEP; j++) begin
               if (!has && !done && rword[j*8 +: 8] == 8'd0) begin
                  edited[j*8 +: 8] = cmd_ff.note;
                  done = 1'b1;
                  ed_added = 1'b1;
               end
            end
         end
         ssps_pkg::KIND_REMOVE: begin
            for (int j = 0; j < NOTES_PER_STEP; j++) begin
               if (rword[j*8 +: 8] == cmd_ff.note) begin
                  edited[j*8 +: 8] = 8'd0;
               end
            end
         end
         ssps_pkg::KIND_CLR_STEP: edited = '0;
         default: edited = rword;
      endcase
   end

   // status flags of the reported step
   always_comb begin
      found = 1'b0;
      empty = 1'b1;
      for (int j = 0; j < NOTES_PER_STEP; j++) begin
         if (shown_ff[j*8 +: 8] == cmd_ff.note) begin
            found = 1'b1;
         end
         if (shown_ff[j*8 +: 8] != 8'd0) begin
            empty = 1'b0;
         end
      end
      shown_ext = 64'(shown_ff);
   end

   always_comb begin
      st_in = st_ff;
      pos_in = pos_ff;
      act_in = act_ff;
      que_in = que_ff;
      qv_in = qv_ff;
      flag_in = flag_ff;
      cnt_in = cnt_ff;
      val_in = val_ff;
      shown_in = shown_ff;
      added_in = added_ff;
      cmd_in_r = cmd_ff;
      rv_in = rv_ff && !rsp_tready;
      rd_in = rd_ff;
      cmd_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en = 1'b0;
      rd_addr = '0;
      clr_all = 1'b0;
      clr_part = 1'b0;
      case (st_ff)
         ssps_pkg::ST_IDLE: begin
            if (cmd_in.valid) begin
               cmd_pop = 1'b1;
               cmd_in_r = cmd_in.cmd;
               added_in = 1'b0;
               st_in = ssps_pkg::ST_SHOW_RD;
               case (cmd_in.cmd.kind)
                  ssps_pkg::KIND_TICK: begin
                     val_in = CW'(pos_ff) + CW'(1);
                     st_in = ssps_pkg::ST_TICK;
                  end
                  ssps_pkg::KIND_RESTART: begin
                     pos_in = '0;
                     act_in = '0;
                     flag_in = 1'b0;
                     qv_in = 1'b0;
                  end
                  ssps_pkg::KIND_SELECT: begin
                     if (cmd_in.cmd.tpart == act_ff) begin
                        act_in = act_ff;
                     end else if (qv_ff && que_ff == cmd_in.cmd.tpart) begin
                        act_in = cmd_in.cmd.tpart;
                        flag_in = 1'b0;
                     end else if (int'(cmd_in.cmd.tpart) < PARTS) begin
                        que_in = cmd_in.cmd.tpart;
                        qv_in = 1'b1;
                        flag_in = 1'b1;
                     end
                  end
                  ssps_pkg::KIND_COPY: begin
                     if (int'(cmd_in.cmd.tpart) < PARTS && cmd_in.cmd.tpart != act_ff) begin
                        cnt_in = '0;
                        st_in = ssps_pkg::ST_COPY_RD;
                     end
                  end
                  ssps_pkg::KIND_CLR_ALL:  clr_all = 1'b1;
                  ssps_pkg::KIND_CLR_PART: clr_part = 1'b1;
                  ssps_pkg::KIND_ADD, ssps_pkg::KIND_REMOVE, ssps_pkg::KIND_CLR_STEP,
                  ssps_pkg::KIND_QUERY: st_in = ssps_pkg::ST_EDIT_RD;
                  default: st_in = ssps_pkg::ST_SHOW_RD;
               endcase
            end
         end
         ssps_pkg::ST_TICK: begin
            // subtract the step count until the position is in range
            if (val_ff >= n) begin
               val_in = val_ff - n;
            end else begin
               pos_in = PW'(val_ff);
               if (flag_ff && val_ff == '0) begin
                  act_in = que_ff;
                  flag_in = 1'b0;
                  qv_in = 1'b0;
               end
               st_in = ssps_pkg::ST_SHOW_RD;
            end
         end
         ssps_pkg::ST_COPY_RD: begin
            rd_en = 1'b1;
            rd_addr = addr_of(act_ff, 6'(cnt_ff));
            st_in = ssps_pkg::ST_COPY_WR;
         end
         ssps_pkg::ST_COPY_WR: begin
            wr_en = 1'b1;
            wr_addr = addr_of(cmd_ff.tpart, 6'(cnt_ff));
            wr_data = rword;
            if (int'(cnt_ff) == STEPS - 1) begin
               st_in = ssps_pkg::ST_SHOW_RD;
            end else begin
               cnt_in = cnt_ff + PW'(1);
               st_in = ssps_pkg::ST_COPY_RD;
            end
         end
         ssps_pkg::ST_EDIT_RD: begin
            rd_en = 1'b1;
            rd_addr = addr_of(act_ff, 6'(cmd_ff.sidx));
            st_in = ssps_pkg::ST_EDIT_WR;
         end
         ssps_pkg::ST_EDIT_WR: begin
            wr_en = (cmd_ff.kind != ssps_pkg::KIND_QUERY);
            wr_addr = addr_of(act_ff, 6'(cmd_ff.sidx));
            wr_data = edited;
            shown_in = edited;
            added_in = ed_added;
            st_in = ssps_pkg::ST_RESP;
         end
         ssps_pkg::ST_SHOW_RD: begin
            rd_en = 1'b1;
            rd_addr = addr_of(act_ff, 6'(pos_ff));
            st_in = ssps_pkg::ST_SHOW_WAIT;
         end
         ssps_pkg::ST_SHOW_WAIT: begin
            shown_in = rword;
            st_in = ssps_pkg::ST_RESP;
         end
         ssps_pkg::ST_RESP: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = {5'd0, added_ff, empty, found,
                        shown_ext[31:24], shown_ext[23:16], shown_ext[15:8], shown_ext[7:0],
                        flag_ff, act_ff[2:0], 4'(pos_ff)};
               st_in = ssps_pkg::ST_IDLE;
            end
         end
         default: st_in = ssps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      shown_ff <= shown_in;
      added_ff <= added_in;
      cmd_ff <= cmd_in_r;
      rd_ff <= rd_in;
      if (rd_en) begin
         rdv_ff <= vld_ff[rd_addr];
      end
      if (reset) begin
         st_ff <= ssps_pkg::ST_IDLE;
         pos_ff <= '0;
         act_ff <= '0;
         que_ff <= '0;
         qv_ff <= 1'b0;
         flag_ff <= 1'b0;
         rv_ff <= 1'b0;
         vld_ff <= '0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in;
         act_ff <= act_in;
         que_ff <= que_in;
         qv_ff <= qv_in;
         flag_ff <= flag_in;
         rv_ff <= rv_in;
         for (int i = 0; i < DEPTH; i++) begin
            if (clr_all || (clr_part && (i / STEPS) == int'(act_ff))) begin
               vld_ff[i] <= 1'b0;
            end
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
endmodule

// ----- design/step_sequencer_pattern_store.sv -----
// Top level of the step sequencer pattern store: front end, command queue,
// back end with pattern RAM, and the steps_in_use register. Uses ssps_pkg.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser action, tdata part/note/step
//   rsp     | out | rsp_tvalid/tready    | tdata position, part, slots, flags
//   csr     | in  | csr_valid/csr_ready  | csr_data steps_in_use
//
// The back end takes an item through pop, RAM read, read wait or edit, and the
// result register; a tick also subtracts the step count until the position is
// in range, and a copy reads and writes each step in turn on the single RAM port.
// Clear all and clear part drop entry valid bits at once; no clearing pass.
// Synchronous active-high reset empties the queue and the result register.
// The front takes up to two items while the back is busy or the result
// stalls; the result register holds until rsp_tready.
`timescale 1ns / 1ps
module step_sequencer_pattern_store #(
   parameter int PARTS          = 8,
   parameter int STEPS          = 16,
   parameter int NOTES_PER_STEP = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] target_part, [11:4] note_value, [15:12] step_index
   input  logic [ssps_pkg::REQ_DATA_W-1:0] req_tdata,
   // [3:0] action
   input  logic [3:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] step_pos, [6:4] part_now, [7] change_pending, [15:8] slot_note_0,
   // [23:16] slot_note_1, [31:24] slot_note_2, [39:32] slot_note_3,
   // [40] note_found, [41] step_empty, [42] note_added, rest zero
   output logic [ssps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [4:0]                      csr_data
);
   ssps_pkg::cmd_chan_type cmd;
   logic                   cmd_pop;
   logic [4:0]             steps_ff;

   // the register takes a write in any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 5'd16;
      end else if (csr_valid) begin
         steps_ff <= csr_data;
      end
   end

   ssps_front #(.STEPS(STEPS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_out    (cmd),
      .cmd_pop    (cmd_pop)
   );

   ssps_back #(
      .PARTS          (PARTS),
      .STEPS          (STEPS),
      .NOTES_PER_STEP (NOTES_PER_STEP)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_in       (cmd),
      .cmd_pop      (cmd_pop),
      .steps_in_use (steps_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );
endmodule

// ----- design/ssps_checker.sv -----
// Port-level checker for the step sequencer pattern store, bound to the top.
// Depends on ssps_pkg for the result width.
`timescale 1ns / 1ps
module ssps_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ssps_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_added_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[42] |-> rsp_tdata[40])
      else $error("added note not reported as found");

   a_added_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[42] |-> !rsp_tdata[41])
      else $error("step empty after an add");
endmodule

bind step_sequencer_pattern_store ssps_port_checker u_ssps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
